// ===== rtl/core/cwrc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwrc_pkg
// Shared types and constants of the color wheel revolution counter.
// ----------------------------------------------------------------------------
package cwrc_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int LEVEL_W      = 16;
	localparam int CH_W         = (CHANNEL_BITS < LEVEL_W) ? CHANNEL_BITS : LEVEL_W;
	localparam int SQ_W         = 2 * CH_W;
	localparam int DIST_W       = SQ_W + 2;
	localparam int REF_W        = 48;
	localparam int RED_LSB      = 32;
	localparam int GREEN_LSB    = 16;
	localparam int BLUE_LSB     = 0;
	localparam int NUM_REFS     = 4;
	localparam int COUNT_W      = 8;
	localparam int CFG_IDX_W    = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(7);

	typedef enum logic [0:0] {
		FUNC_START = 1'b0,
		FUNC_RUN   = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		CLR_RED    = 2'd0,
		CLR_GREEN  = 2'd1,
		CLR_BLUE   = 2'd2,
		CLR_YELLOW = 2'd3
	} color_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF_RED    = 3'd0,
		CFG_REF_GREEN  = 3'd1,
		CFG_REF_BLUE   = 3'd2,
		CFG_REF_YELLOW = 3'd3,
		CFG_REV_LIMIT  = 3'd4
	} cfg_idx_t;

	typedef logic [REF_W-1:0] ref_word_t;

	typedef struct packed {
		func_t               func;
		logic [LEVEL_W-1:0]  red_level;
		logic [LEVEL_W-1:0]  green_level;
		logic [LEVEL_W-1:0]  blue_level;
	} in_item_t;

	typedef struct packed {
		color_t              color_class;
		logic [COUNT_W-1:0]  revolution_count;
		logic                done_res;
		logic                motor_on;
	} out_item_t;

	typedef struct packed {
		logic   advance;
		func_t  func;
		color_t cls;
	} trk_req_t;

endpackage

// ===== rtl/core/cwrc_classify.sv =====
// ----------------------------------------------------------------------------
// cwrc_classify
// Nearest reference color by exact squared distance, ties to the lower class.
// ----------------------------------------------------------------------------
module cwrc_classify (
	input  cwrc_pkg::in_item_t                    item,
	input  cwrc_pkg::ref_word_t [cwrc_pkg::NUM_REFS-1:0] refs,
	output cwrc_pkg::color_t                      cls
);
	import cwrc_pkg::*;

	logic [CH_W-1:0]   lvl_r, lvl_g, lvl_b;
	logic [DIST_W-1:0] ref_dist [NUM_REFS];

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
	                                            input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	assign lvl_r = item.red_level[CH_W-1:0];
	assign lvl_g = item.green_level[CH_W-1:0];
	assign lvl_b = item.blue_level[CH_W-1:0];

	always_comb begin
		for (int i = 0; i < NUM_REFS; i++) begin
			ref_dist[i] = DIST_W'(sq_diff(refs[i][RED_LSB +: CH_W], lvl_r))
			            + DIST_W'(sq_diff(refs[i][GREEN_LSB +: CH_W], lvl_g))
			            + DIST_W'(sq_diff(refs[i][BLUE_LSB +: CH_W], lvl_b));
		end
	end

	always_comb begin
		logic [DIST_W-1:0] best_d;
		best_d = ref_dist[0];
		cls    = CLR_RED;
		for (int i = 1; i < NUM_REFS; i++) begin
			if (ref_dist[i] < best_d) begin
				best_d = ref_dist[i];
				cls    = color_t'(i);
			end
		end
	end

endmodule

// ===== rtl/core/cwrc_tracker.sv =====
// ----------------------------------------------------------------------------
// cwrc_tracker
// Start color, revolution count, finished flag and motor state.
// ----------------------------------------------------------------------------
module cwrc_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwrc_pkg::trk_req_t            req,
	input  logic [cwrc_pkg::COUNT_W-1:0]  limit,
	output cwrc_pkg::out_item_t           res
);
	import cwrc_pkg::*;

	color_t             start_q, last_q;
	logic               start_valid_q, done_q, motor_q;
	logic [COUNT_W-1:0] count_q;

	color_t             start_d, last_d;
	logic               start_valid_d, done_d, motor_d;
	logic [COUNT_W-1:0] count_d;

	always_comb begin
		start_d       = start_q;
		last_d        = req.cls;
		start_valid_d = start_valid_q;
		done_d        = done_q;
		motor_d       = motor_q;
		count_d       = count_q;
		unique case (req.func)
			FUNC_START: begin
				start_d       = req.cls;
				start_valid_d = 1'b1;
				motor_d       = 1'b1;
			end
			FUNC_RUN: begin
				if (start_valid_q && req.cls == start_q && req.cls != last_q &&
				    count_q != COUNT_MAX) begin
					count_d = count_q + 1'b1;
				end
				if (count_d > limit) begin
					done_d  = 1'b1;
					motor_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q       <= CLR_RED;
			last_q        <= CLR_RED;
			start_valid_q <= 1'b0;
			done_q        <= 1'b0;
			motor_q       <= 1'b0;
			count_q       <= '0;
		end else if (req.advance) begin
			start_q       <= start_d;
			last_q        <= last_d;
			start_valid_q <= start_valid_d;
			done_q        <= done_d;
			motor_q       <= motor_d;
			count_q       <= count_d;
		end
	end

	assign res.color_class      = req.cls;
	assign res.revolution_count = count_d;
	assign res.done_res         = done_d;
	assign res.motor_on         = motor_d;

endmodule

// ===== rtl/core/color_wheel_revolution_counter.sv =====
// ----------------------------------------------------------------------------
// color_wheel_revolution_counter
// Classifies sensor samples against four reference colors and counts
// revolutions of the wheel back into the starting color.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one RGB request per handshake; func selects start or run.
//   result channel: one result per sample, in order: class, count after the
//     sample, sticky finished flag and motor state.
//   cfg channel: cfg_index picks a register in list order (four reference
//     colors, then the revolution limit); other indexes are dropped. It is
//     always ready; write only while no sample is in flight.
//   Path: sample register, then result register.
//   Throughput: one sample per cycle while result_ready is high. Classification
//     and the state update both sit between the sample register and the result
//     register, since the next sample needs this one's count and last color.
//   Reset: references clear to zero, the limit to seven, no start recorded,
//     count zero, motor off, both pipeline slots empty.
//   Stall: the result holds while result_ready is low; one more sample may
//     wait in the sample register, then sample_ready drops.
// ----------------------------------------------------------------------------
module color_wheel_revolution_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  cwrc_pkg::in_item_t                sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output cwrc_pkg::out_item_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cwrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cwrc_pkg::REF_W-1:0]        cfg_data
);
	import cwrc_pkg::*;

	ref_word_t [NUM_REFS-1:0] refs_q;
	logic [COUNT_W-1:0]       limit_q;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	color_t    cls;
	trk_req_t  trk_req;
	out_item_t trk_res;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refs_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REF_RED:    refs_q[CLR_RED]    <= cfg_data;
				CFG_REF_GREEN:  refs_q[CLR_GREEN]  <= cfg_data;
				CFG_REF_BLUE:   refs_q[CLR_BLUE]   <= cfg_data;
				CFG_REF_YELLOW: refs_q[CLR_YELLOW] <= cfg_data;
				CFG_REV_LIMIT:  limit_q            <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample;
		end
	end

	cwrc_classify u_classify (
		.item (item_s1),
		.refs (refs_q),
		.cls  (cls)
	);

	assign trk_req.advance = advance;
	assign trk_req.func    = item_s1.func;
	assign trk_req.cls     = cls;

	cwrc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trk_req),
		.limit  (limit_q),
		.res    (trk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= trk_res;
		end
	end

endmodule

// ===== rtl/core/cwrc_checker.sv =====
// ----------------------------------------------------------------------------
// cwrc_checker
// Port-level checks of the revolution counter, bound to the top level.
// ----------------------------------------------------------------------------
module cwrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                sample_ready,
	input logic                result_valid,
	input logic                result_ready,
	input cwrc_pkg::out_item_t result
);
	import cwrc_pkg::*;

	logic               seen_q, done_seen_q;
	logic [COUNT_W-1:0] count_seen_q;
	logic               res_acc;

	assign res_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			done_seen_q  <= 1'b0;
			count_seen_q <= '0;
		end else if (res_acc) begin
			seen_q       <= 1'b1;
			done_seen_q  <= done_seen_q || result.done_res;
			count_seen_q <= result.revolution_count;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_seen_q |-> result.done_res)
		else $error("finished flag cleared");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |-> result.revolution_count >= count_seen_q)
		else $error("revolution count went down");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample stalled with empty result slot");

endmodule

bind color_wheel_revolution_counter cwrc_checker u_cwrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== dv/color_wheel_revolution_counter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_wheel_revolution_counter_tb
// Sends RGB sensor samples through the color wheel revolution counter under
// random idling on both channels. An in-bench tracker classifies each sample
// against the programmed reference colors and follows the start color,
// revolution count, finished flag and motor state. Every result is compared
// field by field in arrival order. Directed tests cover reset defaults,
// counting before and after a start, restart, tie order and count
// saturation. Random wheel phases follow under changing settings.
// ----------------------------------------------------------------------------
module color_wheel_revolution_counter_tb;
	import cwrc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((1 << CH_W) - 1);
	localparam ref_word_t PAL_RED    = 48'hFFFF_0000_0000;
	localparam ref_word_t PAL_GREEN  = 48'h0000_FFFF_0000;
	localparam ref_word_t PAL_BLUE   = 48'h0000_0000_FFFF;
	localparam ref_word_t PAL_YELLOW = 48'hFFFF_FFFF_0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	in_item_t             sample = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b1;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	ref_word_t            cfg_data = '0;

	color_wheel_revolution_counter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	ref_word_t    ref_color [NUM_REFS];
	logic [7:0]   rev_limit;
	color_t       wheel_start;
	color_t       wheel_last;
	bit           wheel_armed;
	logic [7:0]   wheel_count;
	bit           wheel_done;
	bit           wheel_motor;

	out_item_t    due_readings [$];
	bit           tx_gaps = 1'b0;
	bit           rx_stalls = 1'b0;
	int           rx_hold = 0;
	int           cycle_count = 0;
	int           n_samples = 0;
	int           n_checked = 0;
	int           n_cfg = 0;
	int           n_fail = 0;

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [63:0] sq_diff(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
		logic [63:0] d;
		d = (a >= b) ? 64'(a - b) : 64'(b - a);
		return d * d;
	endfunction

	function automatic logic [63:0] color_dist(ref_word_t w, logic [LEVEL_W-1:0] r,
			logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b);
		return sq_diff(w[RED_LSB +: LEVEL_W] & LEVEL_MASK, r)
			+ sq_diff(w[GREEN_LSB +: LEVEL_W] & LEVEL_MASK, g)
			+ sq_diff(w[BLUE_LSB +: LEVEL_W] & LEVEL_MASK, b);
	endfunction

	function automatic color_t nearest_color(logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
			logic [LEVEL_W-1:0] b);
		logic [63:0] best_d;
		logic [63:0] d;
		color_t      best;
		best = CLR_RED;
		best_d = color_dist(ref_color[0], r, g, b);
		for (int i = 1; i < NUM_REFS; i++) begin
			d = color_dist(ref_color[i], r, g, b);
			if (d < best_d) begin
				best_d = d;
				best = color_t'(i);
			end
		end
		return best;
	endfunction

	function automatic out_item_t track_sample(in_item_t item);
		color_t    cls;
		out_item_t reading;
		cls = nearest_color(item.red_level & LEVEL_MASK, item.green_level & LEVEL_MASK,
			item.blue_level & LEVEL_MASK);
		if (item.func == FUNC_START) begin
			wheel_start = cls;
			wheel_last = cls;
			wheel_armed = 1'b1;
			wheel_motor = 1'b1;
		end else begin
			if (wheel_armed && cls == wheel_start && cls != wheel_last && wheel_count != COUNT_MAX)
				wheel_count = wheel_count + 8'd1;
			wheel_last = cls;
			if (wheel_count > rev_limit) begin
				wheel_done = 1'b1;
				wheel_motor = 1'b0;
			end
		end
		reading.color_class = cls;
		reading.revolution_count = wheel_count;
		reading.done_res = wheel_done;
		reading.motor_on = wheel_motor;
		return reading;
	endfunction

	function automatic logic [LEVEL_W-1:0] jitter(logic [LEVEL_W-1:0] v, int spread);
		int x;
		x = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
		if (x < 0)
			x = 0;
		if (x > 65535)
			x = 65535;
		return LEVEL_W'(x);
	endfunction

	task automatic send_sample(func_t f, logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
			logic [LEVEL_W-1:0] b);
		in_item_t item;
		int       gap;
		item.func = f;
		item.red_level = r;
		item.green_level = g;
		item.blue_level = b;
		gap = tx_gaps ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			sample_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample = item;
		sample_valid = 1'b1;
		do @(posedge clk); while (!sample_ready);
		due_readings.push_back(track_sample(item));
		n_samples++;
	endtask

	task automatic send_color(func_t f, color_t c, int spread);
		ref_word_t w;
		w = ref_color[c];
		send_sample(f, jitter(w[RED_LSB +: LEVEL_W], spread),
			jitter(w[GREEN_LSB +: LEVEL_W], spread), jitter(w[BLUE_LSB +: LEVEL_W], spread));
	endtask

	task automatic send_noise(func_t f);
		send_sample(f, LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom));
	endtask

	// hold off until every request has its result
	task automatic settle();
		@(negedge clk);
		sample_valid = 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, ref_word_t data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_REF_RED:    ref_color[CLR_RED] = data;
			CFG_REF_GREEN:  ref_color[CLR_GREEN] = data;
			CFG_REF_BLUE:   ref_color[CLR_BLUE] = data;
			CFG_REF_YELLOW: ref_color[CLR_YELLOW] = data;
			CFG_REV_LIMIT:  rev_limit = data[7:0];
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_refs(ref_word_t r, ref_word_t g, ref_word_t b, ref_word_t y);
		cfg_write(CFG_REF_RED, r);
		cfg_write(CFG_REF_GREEN, g);
		cfg_write(CFG_REF_BLUE, b);
		cfg_write(CFG_REF_YELLOW, y);
	endtask

	task automatic set_limit(logic [7:0] lim);
		cfg_write(CFG_REV_LIMIT, {40'({$urandom, $urandom}), lim});
	endtask

	task automatic test_reset_defaults();
		send_sample(FUNC_RUN, '1, '1, '1);
		send_sample(FUNC_RUN, '0, '0, '0);
		send_sample(FUNC_START, 16'h1234, 16'hABCD, 16'h8001);
		send_sample(FUNC_RUN, 16'h7FFF, 16'h0001, 16'hFFFE);
	endtask

	task automatic test_basic_count();
		set_refs(PAL_RED, PAL_GREEN, PAL_BLUE, PAL_YELLOW);
		set_limit(8'd0);
		send_color(FUNC_RUN, CLR_GREEN, 0);
		send_color(FUNC_RUN, CLR_RED, 0);
		send_color(FUNC_RUN, CLR_GREEN, 0);
		send_color(FUNC_START, CLR_RED, 0);
		send_color(FUNC_RUN, CLR_RED, 0);
		send_color(FUNC_RUN, CLR_GREEN, 0);
		send_color(FUNC_RUN, CLR_RED, 0);
		send_color(FUNC_RUN, CLR_BLUE, 0);
		send_color(FUNC_RUN, CLR_RED, 0);
		send_color(FUNC_START, CLR_YELLOW, 0);
		send_color(FUNC_RUN, CLR_RED, 0);
	endtask

	task automatic test_tie_order();
		set_refs('1, '1, '1, '1);
		send_sample(FUNC_RUN, '0, '0, '0);
		send_sample(FUNC_RUN, '1, '1, '1);
		set_refs('0, 48'h0002_0000_0000, '1, '1);
		send_sample(FUNC_RUN, 16'd1, 16'd0, 16'd0);
		set_refs('1, '0, 48'h0000_0000_0002, '1);
		send_sample(FUNC_RUN, 16'd0, 16'd0, 16'd1);
		set_refs('1, '1, '0, 48'h0000_0002_0000);
		send_sample(FUNC_RUN, 16'd0, 16'd1, 16'd0);
	endtask

	task automatic test_saturation();
		set_refs(PAL_RED, PAL_GREEN, PAL_BLUE, PAL_YELLOW);
		set_limit(8'd255);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		send_color(FUNC_START, CLR_RED, 60);
		for (int i = 0; i < 520; i++) begin
			if (i == 260)
				settle();
			send_color(FUNC_RUN, (i % 2 == 0) ? CLR_GREEN : CLR_RED, 60);
		end
		set_limit(8'd254);
		send_color(FUNC_RUN, CLR_GREEN, 60);
		send_color(FUNC_RUN, CLR_RED, 60);
	endtask

	task automatic random_refs();
		ref_word_t pal [NUM_REFS];
		pal[0] = PAL_RED;
		pal[1] = PAL_GREEN;
		pal[2] = PAL_BLUE;
		pal[3] = PAL_YELLOW;
		if ($urandom_range(0, 2) == 0) begin
			set_refs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
		end else begin
			for (int i = 0; i < NUM_REFS; i++)
				pal[i] = {jitter(pal[i][RED_LSB +: LEVEL_W], 12000),
					jitter(pal[i][GREEN_LSB +: LEVEL_W], 12000),
					jitter(pal[i][BLUE_LSB +: LEVEL_W], 12000)};
			set_refs(pal[0], pal[1], pal[2], pal[3]);
		end
	endtask

	task automatic run_wheel(int n, int spread, int noise_pct);
		color_t order [NUM_REFS];
		color_t tmp;
		int     j;
		int     pos;
		int     pick;
		for (int i = 0; i < NUM_REFS; i++)
			order[i] = color_t'(i);
		for (int i = NUM_REFS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		pos = 0;
		send_color(FUNC_START, order[0], spread);
		for (int k = 1; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < noise_pct) begin
				send_noise(func_t'($urandom_range(0, 1)));
			end else if (pick < noise_pct + 3) begin
				send_color(FUNC_START, order[pos], spread);
			end else begin
				if ($urandom_range(0, 1) == 1)
					pos = (pos + 1) % NUM_REFS;
				send_color(FUNC_RUN, order[pos], spread);
			end
		end
	endtask

	task automatic test_random_wheel();
		logic [7:0] lim;
		for (int ph = 0; ph < 6; ph++) begin
			tx_gaps = (ph != 0);
			rx_stalls = (ph != 0) && (ph != 3);
			random_refs();
			case (ph)
				0: lim = 8'd0;
				1: lim = 8'd254;
				2: lim = 8'd1;
				3: lim = 8'd255;
				default: lim = 8'($urandom_range(2, 12));
			endcase
			set_limit(lim);
			if (ph == 4)
				cfg_write(CFG_IDX_W'(CFG_REV_LIMIT) + CFG_IDX_W'($urandom_range(1,
					(1 << CFG_IDX_W) - 1 - CFG_REV_LIMIT)), 48'({$urandom, $urandom}));
			run_wheel(135, (ph % 2 == 0) ? 400 : 3000, 10);
		end
	endtask

	always @(negedge clk) begin
		if (!rx_stalls) begin
			result_ready = 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			result_ready = ~result_ready;
			rx_hold = result_ready ? $urandom_range(0, 12) : gap_len();
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (due_readings.size() == 0) begin
				$error("result with no pending sample: class %0d count %0d",
					result.color_class, result.revolution_count);
				n_fail++;
			end else begin
				want = due_readings.pop_front();
				n_checked++;
				if (result.color_class !== want.color_class) begin
					$error("color_class: expected %0d, got %0d", want.color_class,
						result.color_class);
					n_fail++;
				end
				if (result.revolution_count !== want.revolution_count) begin
					$error("revolution_count: expected %0d, got %0d", want.revolution_count,
						result.revolution_count);
					n_fail++;
				end
				if (result.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, result.done_res);
					n_fail++;
				end
				if (result.motor_on !== want.motor_on) begin
					$error("motor_on: expected %0d, got %0d", want.motor_on, result.motor_on);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_REFS; i++)
			ref_color[i] = '0;
		rev_limit = LIMIT_RESET;
		wheel_start = CLR_RED;
		wheel_last = CLR_RED;
		wheel_armed = 1'b0;
		wheel_count = '0;
		wheel_done = 1'b0;
		wheel_motor = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_basic_count();
		test_tie_order();
		test_saturation();
		test_random_wheel();
		settle();
		repeat (10) @(posedge clk);
		if (due_readings.size() != 0) begin
			$error("%0d results never arrived", due_readings.size());
			n_fail++;
		end
		$display("covered %0d samples and %0d register writes, %0d results checked", n_samples,
			n_cfg, n_checked);
		$display("directed reset, restart, tie and saturation cases, then random wheel phases");
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== color_wheel_revolution_counter.f =====
rtl/core/cwrc_pkg.sv
rtl/core/cwrc_classify.sv
rtl/core/cwrc_tracker.sv
rtl/core/color_wheel_revolution_counter.sv
rtl/core/cwrc_checker.sv
dv/color_wheel_revolution_counter_tb.sv
